// ----- rtl/core/m3i_pkg.sv -----
// Package for the 3x3 matrix inverse block.
// Holds default widths, the cofactor operand table and the pipeline latency.
// No dependencies.
`default_nettype none

package m3i_pkg;

    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int TOL_W          = 31;

    // Cofactor k is e[a]*e[b] - e[c]*e[d], row-major element indices.
    localparam int COF_IDX [9][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    // Cycles from an accepted start to the result strobe.
    function automatic int latency(input int w);
        return w + 9;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/m3i_cof_lane.sv -----
// One cofactor lane: a*b - c*d over two pipeline stages.
// Depends on nothing but its parameter.
`default_nettype none

module m3i_cof_lane #(
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic signed [ELEM_WIDTH-1:0] i_a,
    input  wire logic signed [ELEM_WIDTH-1:0] i_b,
    input  wire logic signed [ELEM_WIDTH-1:0] i_c,
    input  wire logic signed [ELEM_WIDTH-1:0] i_d,
    output logic signed [2*ELEM_WIDTH:0]      o_cof
);
    localparam int PW = 2 * ELEM_WIDTH;

    logic signed [PW-1:0] r_pab;
    logic signed [PW-1:0] r_pcd;
    logic signed [PW:0]   r_cof;

    always_ff @(posedge i_clk) begin
        r_pab <= PW'(i_a) * PW'(i_b);
        r_pcd <= PW'(i_c) * PW'(i_d);
        r_cof <= (PW+1)'(r_pab) - (PW+1)'(r_pcd);
    end

    assign o_cof = r_cof;

endmodule

`default_nettype wire

// ----- rtl/core/m3i_det.sv -----
// Determinant merge: first-row expansion from three cofactors, then the
// singular test against the tolerance. Four stages. Uses m3i_pkg.
`default_nettype none

module m3i_det #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic signed [ELEM_WIDTH-1:0]  i_e [3],
    input  wire logic signed [2*ELEM_WIDTH:0]  i_cof [3],
    input  wire logic [m3i_pkg::TOL_W-1:0]     i_tol,
    output logic [3*ELEM_WIDTH+2:0]            o_absd,
    output logic                               o_dneg,
    output logic                               o_inv
);
    localparam int W  = ELEM_WIDTH;
    localparam int DW = 3 * W + 3;
    localparam int TH = m3i_pkg::TOL_W + 2 * FRAC_BITS;
    localparam int TW = (DW > TH) ? DW : TH;

    logic signed [W-1:0]  r_e1 [3];
    logic signed [W-1:0]  r_e2 [3];
    logic signed [2*W:0]  r_lo [3];
    logic signed [2*W:0]  r_hi [3];
    logic signed [DW-1:0] r_t  [3];
    logic signed [DW-1:0] r_d;
    logic [DW-1:0]        r_absd;
    logic                 r_dneg;
    logic                 r_inv;
    logic [DW-1:0]        n_absd;

    // The cofactor is split into a low unsigned half and a signed high part.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_e1[i] <= i_e[i];
            r_e2[i] <= r_e1[i];
            r_lo[i] <= (2*W+1)'(r_e2[i])
                       * (2*W+1)'($signed({1'b0, i_cof[i][W-1:0]}));
            r_hi[i] <= (2*W+1)'(r_e2[i]) * (2*W+1)'($signed(i_cof[i][2*W:W]));
            r_t[i]  <= (DW'(r_hi[i]) <<< W) + DW'(r_lo[i]);
        end
        r_d    <= r_t[0] + r_t[1] + r_t[2];
        r_absd <= n_absd;
        r_dneg <= r_d[DW-1];
        r_inv  <= TW'(n_absd) > (TW'(i_tol) << (2 * FRAC_BITS));
    end

    assign n_absd = r_d[DW-1] ? DW'(-r_d) : DW'(r_d);
    assign o_absd = r_absd;
    assign o_dneg = r_dneg;
    assign o_inv  = r_inv;

endmodule

`default_nettype wire

// ----- rtl/core/m3i_div_lane.sv -----
// One output lane: rounded cofactor / determinant by a pipelined restoring
// divider, one quotient bit per stage, then saturation and singular zeroing.
`default_nettype none

module m3i_div_lane #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic signed [2*ELEM_WIDTH:0]  i_cof,
    input  wire logic [3*ELEM_WIDTH+2:0]       i_absd,
    input  wire logic                          i_dneg,
    input  wire logic                          i_inv,
    output logic signed [ELEM_WIDTH-1:0]       o_elem
);
    localparam int W  = ELEM_WIDTH;
    localparam int DW = 3 * W + 3;
    localparam int NW = 2 * W + 2 * FRAC_BITS + 2;
    localparam int DN = DW + W + 2;
    localparam int XW = ((NW > DN) ? NW : DN) + 1;
    localparam int NS = W + 2;

    logic [XW-1:0] r_rem [NS];
    logic [DW-1:0] r_den [NS];
    logic [W-1:0]  r_q   [NS];
    logic          r_big [NS];
    logic          r_neg [NS];
    logic          r_inv [NS];
    logic signed [W-1:0] r_elem;

    logic [2*W:0]  n_mag;
    logic [W-1:0]  n_lim;
    logic [W-1:0]  n_sat;

    // Numerator 2|C|*2^(2F) + |D| over 2|D| gives round half away from zero.
    assign n_mag = i_cof[2*W] ? (2*W+1)'(-i_cof) : (2*W+1)'(i_cof);

    always_ff @(posedge i_clk) begin
        r_rem[0] <= (XW'(n_mag[2*W-1:0]) << (2 * FRAC_BITS + 1)) + XW'(i_absd);
        r_den[0] <= i_absd;
        r_q[0]   <= '0;
        r_big[0] <= 1'b0;
        r_neg[0] <= i_cof[2*W] ^ i_dneg;
        r_inv[0] <= i_inv;

        // Quotient of 2^W or more always saturates.
        r_rem[1] <= r_rem[0];
        r_den[1] <= r_den[0];
        r_q[1]   <= '0;
        r_big[1] <= r_rem[0] >= (XW'(r_den[0]) << (W + 1));
        r_neg[1] <= r_neg[0];
        r_inv[1] <= r_inv[0];
    end

    for (genvar i = 0; i < W; i++) begin : g_step
        localparam int B = W - 1 - i;
        logic [XW-1:0] n_sub;
        logic          n_ge;
        assign n_sub = XW'(r_den[i+1]) << (B + 1);
        assign n_ge  = r_rem[i+1] >= n_sub;
        always_ff @(posedge i_clk) begin
            r_rem[i+2] <= n_ge ? r_rem[i+1] - n_sub : r_rem[i+1];
            r_den[i+2] <= r_den[i+1];
            r_q[i+2]   <= r_q[i+1] | (W'(n_ge) << B);
            r_big[i+2] <= r_big[i+1];
            r_neg[i+2] <= r_neg[i+1];
            r_inv[i+2] <= r_inv[i+1];
        end
    end

    assign n_lim = r_neg[NS-1] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
    assign n_sat = (r_big[NS-1] || r_q[NS-1] > n_lim) ? n_lim : r_q[NS-1];

    always_ff @(posedge i_clk) begin
        if (!r_inv[NS-1]) begin
            r_elem <= '0;
        end else if (r_neg[NS-1]) begin
            r_elem <= $signed(-n_sat);
        end else begin
            r_elem <= $signed(n_sat);
        end
    end

    assign o_elem = r_elem;

endmodule

`default_nettype wire

// ----- rtl/core/matrix3_inverse_top.sv -----
// 3x3 matrix inverse, Q format, adjugate over determinant with rounding.
// Throughput: one matrix per cycle; busy is never raised. The divider lanes,
// one quotient bit per stage, set the depth.
// Reset (synchronous, active low) clears in-flight strobes and the tolerance.
// Results cannot be stalled; o_valid lasts one cycle per matrix.
`default_nettype none

module matrix3_inverse_top #(
    parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [ELEM_WIDTH-1:0]  i_in_r0c0,
    input  wire logic signed [ELEM_WIDTH-1:0]  i_in_r0c1,
    input  wire logic signed [ELEM_WIDTH-1:0]  i_in_r0c2,
    input  wire logic signed [ELEM_WIDTH-1:0]  i_in_r1c0,
    input  wire logic signed [ELEM_WIDTH-1:0]  i_in_r1c1,
    input  wire logic signed [ELEM_WIDTH-1:0]  i_in_r1c2,
    input  wire logic signed [ELEM_WIDTH-1:0]  i_in_r2c0,
    input  wire logic signed [ELEM_WIDTH-1:0]  i_in_r2c1,
    input  wire logic signed [ELEM_WIDTH-1:0]  i_in_r2c2,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [m3i_pkg::TOL_W-1:0]     i_cfg_data,
    output logic                               o_valid,
    output logic signed [ELEM_WIDTH-1:0]       o_out_r0c0,
    output logic signed [ELEM_WIDTH-1:0]       o_out_r0c1,
    output logic signed [ELEM_WIDTH-1:0]       o_out_r0c2,
    output logic signed [ELEM_WIDTH-1:0]       o_out_r1c0,
    output logic signed [ELEM_WIDTH-1:0]       o_out_r1c1,
    output logic signed [ELEM_WIDTH-1:0]       o_out_r1c2,
    output logic signed [ELEM_WIDTH-1:0]       o_out_r2c0,
    output logic signed [ELEM_WIDTH-1:0]       o_out_r2c1,
    output logic signed [ELEM_WIDTH-1:0]       o_out_r2c2,
    output logic                               o_invertible
);
    localparam int W   = ELEM_WIDTH;
    localparam int DW  = 3 * W + 3;
    localparam int LAT = m3i_pkg::latency(W);
    localparam int ILAT = W + 3;

    logic signed [W-1:0]  w_e    [9];
    logic signed [2*W:0]  w_cof  [9];
    logic signed [2*W:0]  r_cd   [4][9];
    logic signed [W-1:0]  w_de   [3];
    logic signed [2*W:0]  w_dc   [3];
    logic signed [W-1:0]  w_out  [9];
    logic [DW-1:0]        w_absd;
    logic                 w_dneg;
    logic                 w_inv;
    logic [ILAT-1:0]      r_inv;
    logic [LAT-1:0]       r_vld;
    logic [m3i_pkg::TOL_W-1:0] r_tol;

    assign w_e[0] = i_in_r0c0;
    assign w_e[1] = i_in_r0c1;
    assign w_e[2] = i_in_r0c2;
    assign w_e[3] = i_in_r1c0;
    assign w_e[4] = i_in_r1c1;
    assign w_e[5] = i_in_r1c2;
    assign w_e[6] = i_in_r2c0;
    assign w_e[7] = i_in_r2c1;
    assign w_e[8] = i_in_r2c2;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
            r_vld <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_tol <= i_cfg_data;
            end
            r_vld <= {r_vld[LAT-2:0], start && !busy};
        end
    end

    for (genvar k = 0; k < 9; k++) begin : g_cof
        m3i_cof_lane #(.ELEM_WIDTH(W)) u_cof (
            .i_clk (i_clk),
            .i_a   (w_e[m3i_pkg::COF_IDX[k][0]]),
            .i_b   (w_e[m3i_pkg::COF_IDX[k][1]]),
            .i_c   (w_e[m3i_pkg::COF_IDX[k][2]]),
            .i_d   (w_e[m3i_pkg::COF_IDX[k][3]]),
            .o_cof (w_cof[k])
        );
    end

    // Cofactors wait while the determinant is formed and tested.
    always_ff @(posedge i_clk) begin
        r_cd[0] <= w_cof;
        for (int s = 1; s < 4; s++) begin
            r_cd[s] <= r_cd[s-1];
        end
        r_inv <= {r_inv[ILAT-2:0], w_inv};
    end

    assign w_de[0] = w_e[0];
    assign w_de[1] = w_e[1];
    assign w_de[2] = w_e[2];
    assign w_dc[0] = w_cof[0];
    assign w_dc[1] = w_cof[3];
    assign w_dc[2] = w_cof[6];

    m3i_det #(.ELEM_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_det (
        .i_clk  (i_clk),
        .i_e    (w_de),
        .i_cof  (w_dc),
        .i_tol  (r_tol),
        .o_absd (w_absd),
        .o_dneg (w_dneg),
        .o_inv  (w_inv)
    );

    for (genvar k = 0; k < 9; k++) begin : g_div
        m3i_div_lane #(.ELEM_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk  (i_clk),
            .i_cof  (r_cd[3][k]),
            .i_absd (w_absd),
            .i_dneg (w_dneg),
            .i_inv  (w_inv),
            .o_elem (w_out[k])
        );
    end

    assign o_valid      = r_vld[LAT-1];
    assign o_invertible = r_inv[ILAT-1];
    assign o_out_r0c0   = w_out[0];
    assign o_out_r0c1   = w_out[1];
    assign o_out_r0c2   = w_out[2];
    assign o_out_r1c0   = w_out[3];
    assign o_out_r1c1   = w_out[4];
    assign o_out_r1c2   = w_out[5];
    assign o_out_r2c0   = w_out[6];
    assign o_out_r2c1   = w_out[7];
    assign o_out_r2c2   = w_out[8];

endmodule

`default_nettype wire

// ----- rtl/core/m3i_checker.sv -----
// Port-level checks for the matrix inverse top level, attached by bind.
// Uses m3i_pkg for the pipeline latency at the default width.
`default_nettype none

module m3i_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid,
    input wire logic o_invertible,
    input wire logic [m3i_pkg::ELEM_WIDTH_DEF-1:0] o_out_r0c0,
    input wire logic [m3i_pkg::ELEM_WIDTH_DEF-1:0] o_out_r1c1,
    input wire logic [m3i_pkg::ELEM_WIDTH_DEF-1:0] o_out_r2c2
);
    localparam int LAT = m3i_pkg::latency(m3i_pkg::ELEM_WIDTH_DEF);

    // Every accepted word produces a result after the fixed latency.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_valid)
        else $error("accepted word produced no result");

    // No result appears without a word accepted the latency earlier.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without an accepted word");

    // A singular result carries zero elements.
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_invertible |-> o_out_r0c0 == '0 && o_out_r1c1 == '0
            && o_out_r2c2 == '0)
        else $error("singular result with nonzero elements");

endmodule

bind matrix3_inverse_top m3i_checker u_m3i_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_invertible (o_invertible),
    .o_out_r0c0   (o_out_r0c0),
    .o_out_r1c1   (o_out_r1c1),
    .o_out_r2c2   (o_out_r2c2)
);

`default_nettype wire
